@@ rtl/rie_pkg.sv @@
package rie_pkg;

	localparam int XLEN          = 32;
	localparam int INSTR_W       = 20;
	localparam int PC_W          = 12;
	localparam int REG_COUNT     = 16;
	localparam int REG_IDX_W     = 4;
	localparam int IO_IDX_W      = 5;
	localparam int MEM_DEPTH_DEF = 4096;
	localparam int IO_COUNT_DEF  = 23;
	localparam int RETI_IO_IDX   = 7;

	localparam logic [REG_IDX_W-1:0] REG_ZERO = 4'd0;
	localparam logic [REG_IDX_W-1:0] REG_IMM  = 4'd1;

	typedef enum logic [7:0] {
		OP_ADD  = 8'd0,
		OP_SUB  = 8'd1,
		OP_MUL  = 8'd2,
		OP_AND  = 8'd3,
		OP_OR   = 8'd4,
		OP_XOR  = 8'd5,
		OP_SLL  = 8'd6,
		OP_SRA  = 8'd7,
		OP_SRL  = 8'd8,
		OP_BEQ  = 8'd9,
		OP_BNE  = 8'd10,
		OP_BLT  = 8'd11,
		OP_BGT  = 8'd12,
		OP_BLE  = 8'd13,
		OP_BGE  = 8'd14,
		OP_JAL  = 8'd15,
		OP_LW   = 8'd16,
		OP_SW   = 8'd17,
		OP_RETI = 8'd18,
		OP_IN   = 8'd19,
		OP_OUT  = 8'd20,
		OP_HALT = 8'd21
	} opcode_t;

	typedef enum logic [1:0] {
		IO_NONE = 2'd0,
		IO_IN   = 2'd1,
		IO_OUT  = 2'd2
	} io_acc_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic pre;
		logic start_ex;
		logic ex1;
		logic ex2;
	} rie_cmd_t;

	typedef struct packed {
		logic clear_last;
	} rie_stat_t;

	// Register 1 stands for the immediate word only where the opcode reads it.
	function automatic logic uses_imm(opcode_t op, logic [REG_IDX_W-1:0] rd,
			logic [REG_IDX_W-1:0] rs, logic [REG_IDX_W-1:0] rt);
		logic res;
		res = 1'b0;
		case (op) inside
			OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR, OP_SLL, OP_SRA, OP_SRL,
			OP_LW, OP_IN: res = (rs == REG_IMM) || (rt == REG_IMM);
			OP_BEQ, OP_BNE, OP_BLT, OP_BGT, OP_BLE, OP_BGE, OP_SW, OP_OUT:
				res = (rd == REG_IMM) || (rs == REG_IMM) || (rt == REG_IMM);
			OP_JAL: res = (rs == REG_IMM);
			default: res = 1'b0;
		endcase
		return res;
	endfunction

endpackage

@@ rtl/risc_instruction_execute.sv @@
// Executes one instruction per accepted beat (start high while busy is low) and
// presents one result beat on done for a single cycle; the receiver cannot stall it.
// An execute beat keeps busy high through the execute states EX1 and EX2, so the
// next instruction is taken only once the last one is through: rs and rt are read
// from the register file in the accept cycle, rd and the synchronous data memory
// word in EX1, write-back happens in EX2, and the result beat is registered from
// EX2. A preload beat writes the data memory at once, leaves busy low and gives
// its result in the next cycle, so preloads may follow every cycle. After reset
// busy stays high while the data memory and register file are swept to zero.
module risc_instruction_execute #(
	parameter int MEM_DEPTH = rie_pkg::MEM_DEPTH_DEF,
	parameter int IO_COUNT  = rie_pkg::IO_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                kind,
	input  logic [rie_pkg::INSTR_W-1:0]         instr_word,
	input  logic signed [rie_pkg::INSTR_W-1:0]  imm_word,
	input  logic [rie_pkg::PC_W-1:0]            cur_pc,
	input  logic [rie_pkg::PC_W-1:0]            preload_addr,
	input  logic signed [rie_pkg::XLEN-1:0]     preload_value,
	output logic                                done,
	output logic [rie_pkg::PC_W-1:0]            next_pc,
	output logic                                halted,
	output logic                                used_imm,
	output logic [1:0]                          io_access,
	output logic [rie_pkg::IO_IDX_W-1:0]        io_index,
	output logic signed [rie_pkg::XLEN-1:0]     io_value
);

	import rie_pkg::*;

	rie_cmd_t  cmd;
	rie_stat_t stat;

	rie_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	rie_dpath #(.MEM_DEPTH(MEM_DEPTH), .IO_COUNT(IO_COUNT)) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.instr_word    (instr_word),
		.imm_word      (imm_word),
		.cur_pc        (cur_pc),
		.preload_addr  (preload_addr),
		.preload_value (preload_value),
		.next_pc       (next_pc),
		.halted        (halted),
		.used_imm      (used_imm),
		.io_access     (io_access),
		.io_index      (io_index),
		.io_value      (io_value)
	);

endmodule

@@ rtl/rie_ram.sv @@
module rie_ram #(
	parameter int WIDTH = rie_pkg::XLEN,
	parameter int DEPTH = rie_pkg::REG_COUNT,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/rie_ctrl.sv @@
module rie_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               kind,
	input  rie_pkg::rie_stat_t stat,
	output rie_pkg::rie_cmd_t  cmd,
	output logic               busy,
	output logic               done
);

	import rie_pkg::*;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EX1,
		ST_EX2
	} state_t;

	state_t state_q;
	logic   done_q;
	logic   accept;

	assign accept = (state_q == ST_IDLE) && start;

	always_comb begin
		cmd.clear    = (state_q == ST_CLEAR);
		cmd.pre      = accept && kind;
		cmd.start_ex = accept && !kind;
		cmd.ex1      = (state_q == ST_EX1);
		cmd.ex2      = (state_q == ST_EX2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.pre || cmd.ex2;
			unique case (state_q)
				ST_CLEAR: begin
					if (stat.clear_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start && !kind) begin
						state_q <= ST_EX1;
					end
				end
				ST_EX1:  state_q <= ST_EX2;
				ST_EX2:  state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

@@ rtl/rie_dpath.sv @@
module rie_dpath #(
	parameter int MEM_DEPTH = rie_pkg::MEM_DEPTH_DEF,
	parameter int IO_COUNT  = rie_pkg::IO_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rie_pkg::rie_cmd_t                   cmd,
	output rie_pkg::rie_stat_t                  stat,
	input  logic [rie_pkg::INSTR_W-1:0]         instr_word,
	input  logic signed [rie_pkg::INSTR_W-1:0]  imm_word,
	input  logic [rie_pkg::PC_W-1:0]            cur_pc,
	input  logic [rie_pkg::PC_W-1:0]            preload_addr,
	input  logic signed [rie_pkg::XLEN-1:0]     preload_value,
	output logic [rie_pkg::PC_W-1:0]            next_pc,
	output logic                                halted,
	output logic                                used_imm,
	output logic [1:0]                          io_access,
	output logic [rie_pkg::IO_IDX_W-1:0]        io_index,
	output logic signed [rie_pkg::XLEN-1:0]     io_value
);

	import rie_pkg::*;

	localparam int AW  = $clog2(MEM_DEPTH);
	localparam int IOW = $clog2(IO_COUNT);

	function automatic logic [XLEN-1:0] shift_f(opcode_t op, logic [XLEN-1:0] x,
			logic [XLEN-1:0] amt);
		logic [4:0]      sh;
		logic [XLEN-1:0] res;
		sh = amt[4:0];
		if (amt[XLEN-1]) begin
			res = x;
		end else if (|amt[XLEN-2:5]) begin
			res = (op == OP_SRA) ? {XLEN{x[XLEN-1]}} : '0;
		end else begin
			case (op)
				OP_SLL:  res = x << sh;
				OP_SRL:  res = x >> sh;
				default: res = XLEN'($signed(x) >>> sh);
			endcase
		end
		return res;
	endfunction

	// Clearing pass counter
	logic [AW-1:0] clr_q;

	// Captured instruction
	logic [INSTR_W-1:0] instr_q;
	logic [XLEN-1:0]    imm_q;
	logic [PC_W-1:0]    pc_q;

	// First execute stage results
	logic [XLEN-1:0] sum_q, a_q, res_q;
	logic            eq_q, lt_ab_q, lt_ba_q, used_q;

	logic [XLEN-1:0] io_q [IO_COUNT];

	// Output registers
	logic [PC_W-1:0]     next_pc_q;
	logic                halted_q, used_imm_q;
	logic [1:0]          io_access_q;
	logic [IO_IDX_W-1:0] io_index_q;
	logic [XLEN-1:0]     io_value_q;

	opcode_t              op;
	logic [REG_IDX_W-1:0] rd, rs, rt;
	logic                 used_now;
	logic [XLEN-1:0]      imm_sel, a, b, d, sum, alu, prod;

	logic [XLEN-1:0] ra_rdata, rb_rdata, mem_rdata;
	logic [REG_IDX_W-1:0] ra_raddr;
	logic            rf_we;
	logic [REG_IDX_W-1:0] rf_waddr;
	logic [XLEN-1:0] rf_wdata;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [XLEN-1:0] mem_wdata;
	logic [XLEN-1:0] pre_addr32;

	logic [IO_IDX_W-1:0] io_idx;
	logic                io_hit;
	logic [XLEN-1:0]     io_rd_val;
	logic [XLEN-1:0]     pc_seq, next32, wb_data;
	logic                taken, rd_wr;

	assign op = opcode_t'(instr_q[19:12]);
	assign rd = instr_q[11:8];
	assign rs = instr_q[7:4];
	assign rt = instr_q[3:0];

	assign used_now = uses_imm(op, rd, rs, rt);

	// Register 1 reads as the immediate when used, register 0 as zero.
	assign imm_sel = used_now ? imm_q : '0;
	assign a = (rs == REG_ZERO) ? '0 : (rs == REG_IMM) ? imm_sel : ra_rdata;
	assign b = (rt == REG_ZERO) ? '0 : (rt == REG_IMM) ? imm_sel : rb_rdata;
	assign d = (rd == REG_ZERO) ? '0 : (rd == REG_IMM) ? (used_q ? imm_q : '0) : ra_rdata;
	assign sum  = a + b;
	assign prod = a * b;

	always_comb begin
		unique case (op)
			OP_ADD:                 alu = sum;
			OP_SUB:                 alu = a - b;
			OP_MUL:                 alu = prod;
			OP_AND:                 alu = a & b;
			OP_OR:                  alu = a | b;
			OP_XOR:                 alu = a ^ b;
			OP_SLL, OP_SRA, OP_SRL: alu = shift_f(op, a, b);
			default:                alu = '0;
		endcase
	end

	// Port A reads rs at accept and rd in the first execute cycle.
	assign ra_raddr = cmd.ex1 ? rd : instr_word[7:4];

	assign rf_we    = cmd.clear || (cmd.ex2 && rd_wr);
	assign rf_waddr = cmd.clear ? clr_q[REG_IDX_W-1:0] : rd;
	assign rf_wdata = cmd.clear ? '0 : wb_data;

	rie_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_a (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rf_waddr),
		.wdata (rf_wdata),
		.raddr (ra_raddr),
		.rdata (ra_rdata)
	);

	rie_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_b (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rf_waddr),
		.wdata (rf_wdata),
		.raddr (instr_word[3:0]),
		.rdata (rb_rdata)
	);

	assign pre_addr32 = XLEN'(preload_addr);
	assign mem_we     = cmd.clear || cmd.pre || (cmd.ex2 && (op == OP_SW));
	assign mem_waddr  = cmd.clear ? clr_q : cmd.pre ? pre_addr32[AW-1:0] : sum_q[AW-1:0];
	assign mem_wdata  = cmd.clear ? '0 : cmd.pre ? preload_value : d;

	rie_ram #(.WIDTH(XLEN), .DEPTH(MEM_DEPTH)) u_dmem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (sum[AW-1:0]),
		.rdata (mem_rdata)
	);

	assign stat.clear_last = (clr_q == AW'(MEM_DEPTH - 1));

	assign io_idx    = sum_q[IO_IDX_W-1:0];
	assign io_hit    = (XLEN'(io_idx) < XLEN'(IO_COUNT));
	assign io_rd_val = io_hit ? io_q[io_idx[IOW-1:0]] : '0;

	assign pc_seq = XLEN'(pc_q) + XLEN'(1) + XLEN'(used_q);

	always_comb begin
		unique case (op)
			OP_BEQ:  taken = eq_q;
			OP_BNE:  taken = !eq_q;
			OP_BLT:  taken = lt_ab_q;
			OP_BGT:  taken = lt_ba_q;
			OP_BLE:  taken = !lt_ba_q;
			OP_BGE:  taken = !lt_ab_q;
			default: taken = 1'b0;
		endcase
	end

	always_comb begin
		next32  = XLEN'(pc_seq[AW-1:0]);
		wb_data = res_q;
		rd_wr   = 1'b0;
		unique case (op)
			OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR, OP_SLL, OP_SRA, OP_SRL: begin
				rd_wr = 1'b1;
			end
			OP_BEQ, OP_BNE, OP_BLT, OP_BGT, OP_BLE, OP_BGE: begin
				if (taken) begin
					next32 = XLEN'(d[AW-1:0]);
				end
			end
			OP_JAL: begin
				rd_wr   = 1'b1;
				wb_data = XLEN'(pc_seq[AW-1:0]);
				next32  = XLEN'(a_q[AW-1:0]);
			end
			OP_LW: begin
				rd_wr   = 1'b1;
				wb_data = mem_rdata;
			end
			OP_RETI: next32 = XLEN'(io_q[RETI_IO_IDX][AW-1:0]);
			OP_IN: begin
				rd_wr   = 1'b1;
				wb_data = io_rd_val;
			end
			OP_HALT: next32 = XLEN'(pc_q);
			default: ;
		endcase
		// Writes to registers 0 and 1 are dropped.
		if (rd == REG_ZERO || rd == REG_IMM) begin
			rd_wr = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			for (int i = 0; i < IO_COUNT; i++) begin
				io_q[i] <= '0;
			end
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.ex2 && (op == OP_OUT) && io_hit) begin
				io_q[io_idx[IOW-1:0]] <= d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_ex) begin
			instr_q <= instr_word;
			imm_q   <= {{(XLEN-INSTR_W){imm_word[INSTR_W-1]}}, imm_word};
			pc_q    <= cur_pc;
		end
		if (cmd.ex1) begin
			sum_q   <= sum;
			a_q     <= a;
			res_q   <= alu;
			eq_q    <= (a == b);
			lt_ab_q <= ($signed(a) < $signed(b));
			lt_ba_q <= ($signed(b) < $signed(a));
			used_q  <= used_now;
		end
		if (cmd.pre) begin
			next_pc_q   <= cur_pc;
			halted_q    <= 1'b0;
			used_imm_q  <= 1'b0;
			io_access_q <= IO_NONE;
			io_index_q  <= '0;
			io_value_q  <= '0;
		end else if (cmd.ex2) begin
			next_pc_q   <= next32[PC_W-1:0];
			halted_q    <= (op == OP_HALT);
			used_imm_q  <= used_q;
			if (op == OP_IN) begin
				io_access_q <= IO_IN;
				io_index_q  <= io_idx;
				io_value_q  <= io_rd_val;
			end else if (op == OP_OUT) begin
				io_access_q <= IO_OUT;
				io_index_q  <= io_idx;
				io_value_q  <= d;
			end else begin
				io_access_q <= IO_NONE;
				io_index_q  <= '0;
				io_value_q  <= '0;
			end
		end
	end

	assign next_pc   = next_pc_q;
	assign halted    = halted_q;
	assign used_imm  = used_imm_q;
	assign io_access = io_access_q;
	assign io_index  = io_index_q;
	assign io_value  = io_value_q;

endmodule

@@ rtl/rie_checker.sv @@
module rie_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input logic                            kind,
	input logic                            done,
	input logic                            halted,
	input logic                            used_imm,
	input logic [1:0]                      io_access,
	input logic [rie_pkg::IO_IDX_W-1:0]    io_index,
	input logic signed [rie_pkg::XLEN-1:0] io_value
);

	import rie_pkg::*;

	// A result beat follows either a preload beat or the last busy cycle.
	a_done_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("result beat without a preceding beat or execution");

	// An execute beat always keeps the block busy in the next cycle.
	a_exec_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !kind) |=> busy)
		else $error("execute beat did not raise busy");

	a_halt_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && halted) |-> (io_access == IO_NONE && !used_imm))
		else $error("halt result carries an access or immediate");

	a_io_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(done && io_access == IO_NONE) |-> (io_index == '0 && io_value == '0))
		else $error("I/O fields set without an I/O access");

	a_io_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (io_access == IO_NONE || io_access == IO_IN || io_access == IO_OUT))
		else $error("undefined I/O access code");

endmodule

bind risc_instruction_execute rie_checker u_rie_checker (.*);

@@ dv/tb_risc_instruction_execute.sv @@
`timescale 1ns / 1ps

module tb_risc_instruction_execute;
	import rie_pkg::*;

	localparam logic KIND_EXEC    = 1'b0;
	localparam logic KIND_PRELOAD = 1'b1;
	localparam logic [7:0] OP_UNUSED_TOP = 8'hFF;
	localparam logic [19:0] IMM_MIN = 20'h80000;
	localparam logic [19:0] IMM_MAX = 20'h7FFFF;
	localparam logic [19:0] IMM_ALL_ONES = 20'hFFFFF;
	localparam int CYCLE_LIMIT = 100000;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic        kind;
		logic [19:0] instr;
		logic [19:0] imm;
		logic [11:0] pc;
		logic [11:0] paddr;
		logic [31:0] pval;
	} insn_beat_t;

	typedef struct packed {
		logic [11:0] next_pc;
		logic        halted;
		logic        used_imm;
		io_acc_t     io_access;
		logic [4:0]  io_index;
		logic [31:0] io_value;
	} exec_outcome_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic kind;
	logic [INSTR_W-1:0] instr_word;
	logic signed [INSTR_W-1:0] imm_word;
	logic [PC_W-1:0] cur_pc;
	logic [PC_W-1:0] preload_addr;
	logic signed [XLEN-1:0] preload_value;
	logic done;
	logic [PC_W-1:0] next_pc;
	logic halted;
	logic used_imm;
	logic [1:0] io_access;
	logic [IO_IDX_W-1:0] io_index;
	logic signed [XLEN-1:0] io_value;

	// Shadow copy of the machine state, updated as each beat is accepted.
	logic [31:0] reg_file [REG_COUNT];
	logic [31:0] data_mem [MEM_DEPTH_DEF];
	logic [31:0] io_bank [IO_COUNT_DEF];

	exec_outcome_t expected_outcomes [$];
	exec_outcome_t want_outcome;
	int mismatches = 0;
	int cycle_count = 0;
	int burst_left = 0;

	risc_instruction_execute dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.instr_word(instr_word),
		.imm_word(imm_word),
		.cur_pc(cur_pc),
		.preload_addr(preload_addr),
		.preload_value(preload_value),
		.done(done),
		.next_pc(next_pc),
		.halted(halted),
		.used_imm(used_imm),
		.io_access(io_access),
		.io_index(io_index),
		.io_value(io_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic logic [31:0] get_reg(logic [3:0] idx, logic [31:0] imm, logic used);
		if (idx == REG_ZERO)
			return '0;
		if (idx == REG_IMM)
			return used ? imm : '0;
		return reg_file[idx];
	endfunction

	function automatic void set_reg(logic [3:0] idx, logic [31:0] value);
		if (idx > REG_IMM)
			reg_file[idx] = value;
	endfunction

	function automatic logic [31:0] shift_value(logic [7:0] op, logic [31:0] x, logic [31:0] amt);
		logic [31:0] res;
		// The amount is signed: negative means no shift, 32 and above saturates.
		if (amt[31])
			return x;
		if (amt >= 32)
			return (op == OP_SRA && x[31]) ? '1 : '0;
		if (op == OP_SLL)
			res = x << amt[4:0];
		else if (op == OP_SRL)
			res = x >> amt[4:0];
		else
			res = $signed(x) >>> amt[4:0];
		return res;
	endfunction

	function automatic exec_outcome_t step_machine(insn_beat_t bt);
		exec_outcome_t o;
		logic [7:0] op;
		logic [3:0] rd, rs, rt;
		logic [31:0] imm, opa, opb, opd, sum;
		logic [11:0] nxt;
		logic used;
		o = '0;
		if (bt.kind == KIND_PRELOAD) begin
			data_mem[bt.paddr] = bt.pval;
			o.next_pc = bt.pc;
			return o;
		end
		op = bt.instr[19:12];
		rd = bt.instr[11:8];
		rs = bt.instr[7:4];
		rt = bt.instr[3:0];
		imm = {{12{bt.imm[19]}}, bt.imm};
		case (op)
			OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR, OP_SLL, OP_SRA, OP_SRL,
			OP_LW, OP_IN:
				used = (rs == REG_IMM) || (rt == REG_IMM);
			OP_BEQ, OP_BNE, OP_BLT, OP_BGT, OP_BLE, OP_BGE, OP_SW, OP_OUT:
				used = (rd == REG_IMM) || (rs == REG_IMM) || (rt == REG_IMM);
			OP_JAL:
				used = (rs == REG_IMM);
			default:
				used = 1'b0;
		endcase
		opa = get_reg(rs, imm, used);
		opb = get_reg(rt, imm, used);
		opd = get_reg(rd, imm, used);
		sum = opa + opb;
		nxt = bt.pc + 12'd1 + {11'd0, used};
		case (op)
			OP_ADD: set_reg(rd, opa + opb);
			OP_SUB: set_reg(rd, opa - opb);
			OP_MUL: set_reg(rd, opa * opb);
			OP_AND: set_reg(rd, opa & opb);
			OP_OR:  set_reg(rd, opa | opb);
			OP_XOR: set_reg(rd, opa ^ opb);
			OP_SLL, OP_SRA, OP_SRL: set_reg(rd, shift_value(op, opa, opb));
			OP_BEQ: if (opa == opb) nxt = opd[11:0];
			OP_BNE: if (opa != opb) nxt = opd[11:0];
			OP_BLT: if ($signed(opa) < $signed(opb)) nxt = opd[11:0];
			OP_BGT: if ($signed(opa) > $signed(opb)) nxt = opd[11:0];
			OP_BLE: if ($signed(opa) <= $signed(opb)) nxt = opd[11:0];
			OP_BGE: if ($signed(opa) >= $signed(opb)) nxt = opd[11:0];
			OP_JAL: begin
				set_reg(rd, {20'd0, nxt});
				nxt = opa[11:0];
			end
			OP_LW: set_reg(rd, data_mem[sum[11:0]]);
			OP_SW: data_mem[sum[11:0]] = opd;
			OP_RETI: nxt = io_bank[RETI_IO_IDX][11:0];
			OP_IN: begin
				o.io_access = IO_IN;
				o.io_index = sum[4:0];
				o.io_value = (sum[4:0] < IO_COUNT_DEF) ? io_bank[sum[4:0]] : '0;
				set_reg(rd, o.io_value);
			end
			OP_OUT: begin
				o.io_access = IO_OUT;
				o.io_index = sum[4:0];
				o.io_value = opd;
				if (sum[4:0] < IO_COUNT_DEF)
					io_bank[sum[4:0]] = opd;
			end
			OP_HALT: begin
				o.halted = 1'b1;
				nxt = bt.pc;
			end
			default: ;
		endcase
		o.next_pc = nxt;
		o.used_imm = used;
		return o;
	endfunction

	function automatic logic [31:0] random_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [19:0] random_imm();
		case ($urandom_range(0, 7))
			0: return IMM_MIN;
			1: return IMM_MAX;
			2: return IMM_ALL_ONES;
			3, 4: return 20'($urandom_range(0, 63));
			default: return 20'($urandom);
		endcase
	endfunction

	function automatic logic [3:0] pick_reg();
		case ($urandom_range(0, 9))
			0, 1: return REG_IMM;
			2: return REG_ZERO;
			default: return 4'($urandom_range(0, 15));
		endcase
	endfunction

	function automatic insn_beat_t exec_beat(logic [7:0] op, logic [3:0] rd, logic [3:0] rs,
			logic [3:0] rt, logic [19:0] imm, logic [11:0] pc);
		insn_beat_t bt;
		bt.kind = KIND_EXEC;
		bt.instr = {op, rd, rs, rt};
		bt.imm = imm;
		bt.pc = pc;
		bt.paddr = 12'($urandom);
		bt.pval = $urandom;
		return bt;
	endfunction

	function automatic insn_beat_t preload_beat(logic [11:0] addr, logic [31:0] value,
			logic [11:0] pc);
		insn_beat_t bt;
		bt.kind = KIND_PRELOAD;
		bt.instr = 20'($urandom);
		bt.imm = 20'($urandom);
		bt.pc = pc;
		bt.paddr = addr;
		bt.pval = value;
		return bt;
	endfunction

	// Called at a rising edge; returns at the edge where the beat was taken,
	// leaving start high so that the next beat can follow without a gap.
	task automatic send_beat(insn_beat_t bt);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		kind <= bt.kind;
		instr_word <= bt.instr;
		imm_word <= bt.imm;
		cur_pc <= bt.pc;
		preload_addr <= bt.paddr;
		preload_value <= bt.pval;
		do @(posedge clk); while (busy);
		expected_outcomes.push_back(step_machine(bt));
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_outcomes.size() == 0) begin
				$error("result beat with nothing outstanding");
				mismatches++;
			end else begin
				want_outcome = expected_outcomes.pop_front();
				if (next_pc !== want_outcome.next_pc) begin
					$error("next_pc: expected %0h, got %0h", want_outcome.next_pc, next_pc);
					mismatches++;
				end
				if (halted !== want_outcome.halted) begin
					$error("halted: expected %0b, got %0b", want_outcome.halted, halted);
					mismatches++;
				end
				if (used_imm !== want_outcome.used_imm) begin
					$error("used_imm: expected %0b, got %0b", want_outcome.used_imm, used_imm);
					mismatches++;
				end
				if (io_access !== want_outcome.io_access) begin
					$error("io_access: expected %0d, got %0d", want_outcome.io_access, io_access);
					mismatches++;
				end
				if (io_index !== want_outcome.io_index) begin
					$error("io_index: expected %0d, got %0d", want_outcome.io_index, io_index);
					mismatches++;
				end
				if (io_value !== want_outcome.io_value) begin
					$error("io_value: expected %0h, got %0h", want_outcome.io_value, io_value);
					mismatches++;
				end
			end
		end
	end

	task automatic test_preload_edges();
		send_beat(preload_beat(12'hFFF, 32'h8000_0000, 12'h000));
	endtask

	task automatic test_alu_and_shifts();
		// The first one also wraps the pc past the top of memory.
		send_beat(exec_beat(OP_ADD, 4'd2, REG_IMM, REG_ZERO, IMM_MIN, 12'hFFF));
		send_beat(exec_beat(OP_ADD, 4'd3, REG_IMM, REG_IMM, IMM_MAX, 12'h010));
		send_beat(exec_beat(OP_SUB, 4'd4, 4'd2, 4'd3, 20'd0, 12'h011));
		send_beat(exec_beat(OP_MUL, 4'd5, 4'd3, 4'd3, 20'd0, 12'h012));
		send_beat(exec_beat(OP_AND, 4'd6, 4'd2, REG_IMM, IMM_ALL_ONES, 12'h013));
		send_beat(exec_beat(OP_OR, 4'd7, 4'd4, 4'd5, 20'd0, 12'h015));
		send_beat(exec_beat(OP_XOR, 4'd8, REG_IMM, 4'd2, 20'h12345, 12'h016));
		send_beat(exec_beat(OP_SLL, 4'd9, 4'd3, REG_IMM, 20'd40, 12'h018));
		send_beat(exec_beat(OP_SRA, 4'd10, 4'd2, REG_IMM, IMM_ALL_ONES, 12'h01A));
		send_beat(exec_beat(OP_SRL, 4'd11, 4'd2, REG_IMM, 20'd31, 12'h01C));
	endtask

	task automatic test_memory_and_io();
		send_beat(exec_beat(OP_LW, 4'd12, REG_IMM, REG_ZERO, 20'd4095, 12'h020));
		send_beat(exec_beat(OP_SW, 4'd3, REG_IMM, REG_ZERO, 20'd100, 12'h022));
		send_beat(exec_beat(OP_OUT, 4'd12, REG_IMM, REG_ZERO, 20'd7, 12'h024));
		send_beat(exec_beat(OP_IN, 4'd13, REG_ZERO, REG_IMM, 20'd7, 12'h026));
		// Indices past the end of the bank: the write is dropped, the read gives zero.
		send_beat(exec_beat(OP_OUT, 4'd3, REG_IMM, REG_ZERO, 20'd30, 12'h028));
		send_beat(exec_beat(OP_IN, 4'd14, REG_IMM, REG_ZERO, 20'd31, 12'h02A));
	endtask

	task automatic test_control_flow();
		send_beat(exec_beat(OP_BEQ, REG_IMM, REG_ZERO, REG_ZERO, IMM_ALL_ONES, 12'h030));
		send_beat(exec_beat(OP_BNE, 4'd2, 4'd3, 4'd3, 20'd0, 12'h031));
		send_beat(exec_beat(OP_BLT, 4'd3, 4'd2, 4'd3, 20'd0, 12'h032));
		send_beat(exec_beat(OP_BGT, REG_IMM, 4'd2, REG_IMM, IMM_MAX, 12'h033));
		send_beat(exec_beat(OP_BLE, 4'd4, 4'd2, 4'd2, 20'd0, 12'h035));
		send_beat(exec_beat(OP_BGE, REG_IMM, REG_ZERO, 4'd12, 20'h00ABC, 12'h036));
		send_beat(exec_beat(OP_JAL, 4'd15, REG_IMM, REG_ZERO, 20'h00123, 12'hFFF));
		send_beat(exec_beat(OP_RETI, 4'd0, 4'd0, 4'd0, 20'd0, 12'h040));
		send_beat(exec_beat(OP_HALT, 4'd0, 4'd0, 4'd0, 20'd0, 12'h555));
		send_beat(exec_beat(OP_UNUSED_TOP, 4'd2, REG_IMM, REG_IMM, IMM_MAX, 12'h041));
	endtask

	task automatic test_random_stream(int count, int preload_pct);
		logic [7:0] op;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < preload_pct) begin
				send_beat(preload_beat($urandom_range(0, 1) ? 12'($urandom_range(0, 63))
					: 12'($urandom), random_word(), 12'($urandom)));
			end else begin
				op = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(22, 255))
					: 8'($urandom_range(0, 21));
				send_beat(exec_beat(op, pick_reg(), pick_reg(), pick_reg(), random_imm(),
					12'($urandom)));
			end
		end
	endtask

	// Pairs that write a location and then read it back, so that loads and I/O
	// reads return something other than zero.
	task automatic test_linked_sequences(int pairs);
		logic [19:0] where;
		for (int i = 0; i < pairs; i++) begin
			case ($urandom_range(0, 2))
				0: begin
					where = 20'($urandom_range(0, 63));
					send_beat(preload_beat(where[11:0], random_word(), 12'($urandom)));
					send_beat(exec_beat(OP_LW, pick_reg(), REG_IMM, REG_ZERO, where,
						12'($urandom)));
				end
				1: begin
					where = random_imm();
					send_beat(exec_beat(OP_SW, pick_reg(), REG_IMM, REG_ZERO, where,
						12'($urandom)));
					send_beat(exec_beat(OP_LW, pick_reg(), REG_ZERO, REG_IMM, where,
						12'($urandom)));
				end
				default: begin
					where = $urandom_range(0, 1) ? 20'(RETI_IO_IDX) : 20'($urandom_range(0, 31));
					send_beat(exec_beat(OP_OUT, pick_reg(), REG_IMM, REG_ZERO, where,
						12'($urandom)));
					if ($urandom_range(0, 1))
						send_beat(exec_beat(OP_IN, pick_reg(), REG_IMM, REG_ZERO, where,
							12'($urandom)));
					else
						send_beat(exec_beat(OP_RETI, pick_reg(), pick_reg(), pick_reg(),
							random_imm(), 12'($urandom)));
				end
			endcase
		end
	endtask

	task automatic test_drain_pause();
		start <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (expected_outcomes.size() != 0);
	endtask

	initial begin
		for (int i = 0; i < REG_COUNT; i++)
			reg_file[i] = '0;
		for (int i = 0; i < MEM_DEPTH_DEF; i++)
			data_mem[i] = '0;
		for (int i = 0; i < IO_COUNT_DEF; i++)
			io_bank[i] = '0;
		arst_n = 1'b0;
		start = 1'b0;
		kind = KIND_EXEC;
		instr_word = '0;
		imm_word = '0;
		cur_pc = '0;
		preload_addr = '0;
		preload_value = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_preload_edges();
		test_alu_and_shifts();
		test_memory_and_io();
		test_control_flow();
		test_random_stream(300, 15);
		test_drain_pause();
		test_linked_sequences(150);
		test_random_stream(250, 10);

		start <= 1'b0;
		while (expected_outcomes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
